@@ src/tun_pkg.sv @@
// Shared widths and payload types for the triangle unit normal pipeline.
package tun_pkg;

	localparam int CoordBits = 24;
	localparam int DiffBits  = CoordBits + 1;
	localparam int ProdBits  = 2 * DiffBits;
	localparam int CrossBits = ProdBits + 1;
	localparam int RedBits   = 31;
	localparam int SqBits    = 2 * RedBits;
	localparam int SumBits   = 64;
	localparam int LenBits   = SumBits / 2;
	localparam int FracBits  = 14;
	localparam int NumBits   = RedBits + FracBits + 1;
	localparam int QBits     = 15;
	localparam int OutBits   = 16;
	localparam int ShBits    = 6;
	localparam int SqrtSteps = SumBits / 2;
	localparam int DivSteps  = QBits;

	typedef struct packed {
		logic [2:0][RedBits-1:0] r;
		logic [2:0]              neg;
		logic                    degen;
	} side_t;

	typedef struct packed {
		logic [2:0] neg;
		logic       degen;
	} div_side_t;

endpackage

@@ src/tun_isqrt.sv @@
// Pipelined 64-bit integer square root, one result bit per stage.
module tun_isqrt (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                in_valid,
	input  logic [tun_pkg::SumBits-1:0]         x,
	input  tun_pkg::side_t                      side_in,
	output logic                                out_valid,
	output logic [tun_pkg::LenBits-1:0]         len,
	output tun_pkg::side_t                      side_out
);

	logic                        v_st  [0:tun_pkg::SqrtSteps];
	logic [tun_pkg::SumBits-1:0] x_st  [0:tun_pkg::SqrtSteps];
	logic [tun_pkg::SumBits-1:0] r_st  [0:tun_pkg::SqrtSteps];
	tun_pkg::side_t              sd_st [0:tun_pkg::SqrtSteps];

	assign v_st[0]  = in_valid;
	assign x_st[0]  = x;
	assign r_st[0]  = '0;
	assign sd_st[0] = side_in;

	for (genvar k = 0; k < tun_pkg::SqrtSteps; k++) begin : g_step
		localparam logic [tun_pkg::SumBits-1:0] Bit =
			tun_pkg::SumBits'(1) << (tun_pkg::SumBits - 2 - 2 * k);
		logic [tun_pkg::SumBits-1:0] trial;
		logic [tun_pkg::SumBits-1:0] x_nxt;
		logic [tun_pkg::SumBits-1:0] r_nxt;

		always_comb begin
			trial = r_st[k] + Bit;
			if (x_st[k] >= trial) begin
				x_nxt = x_st[k] - trial;
				r_nxt = (r_st[k] >> 1) + Bit;
			end else begin
				x_nxt = x_st[k];
				r_nxt = r_st[k] >> 1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_st[k+1] <= 1'b0;
			end else if (en) begin
				v_st[k+1] <= v_st[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_st[k+1]  <= x_nxt;
				r_st[k+1]  <= r_nxt;
				sd_st[k+1] <= sd_st[k];
			end
		end
	end

	assign out_valid = v_st[tun_pkg::SqrtSteps];
	assign len       = r_st[tun_pkg::SqrtSteps][tun_pkg::LenBits-1:0];
	assign side_out  = sd_st[tun_pkg::SqrtSteps];

endmodule

@@ src/tun_div.sv @@
// Pipelined restoring divider, three lanes sharing one divisor, one quotient bit per stage.
module tun_div (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    en,
	input  logic                                    in_valid,
	input  logic [2:0][tun_pkg::NumBits-1:0]        num,
	input  logic [tun_pkg::LenBits-1:0]             den,
	input  tun_pkg::div_side_t                      side_in,
	output logic                                    out_valid,
	output logic [2:0][tun_pkg::QBits-1:0]          quo,
	output tun_pkg::div_side_t                      side_out
);

	logic                                v_st  [0:tun_pkg::DivSteps];
	logic [2:0][tun_pkg::NumBits-1:0]    rem_st[0:tun_pkg::DivSteps];
	logic [2:0][tun_pkg::QBits-1:0]      q_st  [0:tun_pkg::DivSteps];
	logic [tun_pkg::LenBits-1:0]         d_st  [0:tun_pkg::DivSteps];
	tun_pkg::div_side_t                  sd_st [0:tun_pkg::DivSteps];

	assign v_st[0]   = in_valid;
	assign rem_st[0] = num;
	assign q_st[0]   = '0;
	assign d_st[0]   = den;
	assign sd_st[0]  = side_in;

	for (genvar k = 0; k < tun_pkg::DivSteps; k++) begin : g_step
		localparam int Sh = tun_pkg::DivSteps - 1 - k;
		logic [tun_pkg::NumBits-1:0]      dsh;
		logic [2:0][tun_pkg::NumBits-1:0] rem_nxt;
		logic [2:0][tun_pkg::QBits-1:0]   q_nxt;

		always_comb begin
			dsh = tun_pkg::NumBits'(d_st[k]) << Sh;
			for (int i = 0; i < 3; i++) begin
				q_nxt[i] = q_st[k][i];
				if (rem_st[k][i] >= dsh) begin
					rem_nxt[i]  = rem_st[k][i] - dsh;
					q_nxt[i][Sh] = 1'b1;
				end else begin
					rem_nxt[i] = rem_st[k][i];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_st[k+1] <= 1'b0;
			end else if (en) begin
				v_st[k+1] <= v_st[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_st[k+1] <= rem_nxt;
				q_st[k+1]   <= q_nxt;
				d_st[k+1]   <= d_st[k];
				sd_st[k+1]  <= sd_st[k];
			end
		end
	end

	assign out_valid = v_st[tun_pkg::DivSteps];
	assign quo       = q_st[tun_pkg::DivSteps];
	assign side_out  = sd_st[tun_pkg::DivSteps];

endmodule

@@ src/triangle_unit_normal_core.sv @@
// Top level: unit face normal of a triangle, fully pipelined.
// Takes one triangle per cycle while the output is not stalled and gives one
// unit normal per triangle, in order. Stages: edges, products, cross product,
// magnitude, shift count, scaling, squares, sum, 32 square root stages,
// rounding numerator, 15 divider stages and the output register. All stages
// advance together; the pipeline holds whenever a result waits at the output
// and m_tready is low. A zero cross product gives a zero normal with tuser set.
module triangle_unit_normal_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// first_x, first_y, first_z, second_x, second_y, second_z, third_x, third_y, third_z
	input  logic [215:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// normal_x, normal_y, normal_z
	output logic [47:0]  m_tdata,
	// degenerate
	output logic [0:0]   m_tuser
);

	localparam int CB = tun_pkg::CoordBits;
	localparam int DB = tun_pkg::DiffBits;
	localparam int PB = tun_pkg::ProdBits;
	localparam int NB = tun_pkg::CrossBits;
	localparam int RB = tun_pkg::RedBits;

	logic en;
	logic out_v_q;

	assign en       = !out_v_q || m_tready;
	assign s_tready = en;

	// stage 1: edge vectors
	logic signed [CB-1:0] c [0:8];
	for (genvar i = 0; i < 9; i++) begin : g_crd
		assign c[i] = s_tdata[i*CB +: CB];
	end

	logic                        v_s1;
	logic signed [2:0][DB-1:0]   u_s1, w_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				u_s1[i] <= DB'(c[3+i]) - DB'(c[i]);
				w_s1[i] <= DB'(c[6+i]) - DB'(c[i]);
			end
		end
	end

	// stage 2: products
	logic                      v_s2;
	logic signed [PB-1:0]      pa_s2 [0:2];
	logic signed [PB-1:0]      pb_s2 [0:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pa_s2[0] <= $signed(u_s1[1]) * $signed(w_s1[2]);
			pb_s2[0] <= $signed(u_s1[2]) * $signed(w_s1[1]);
			pa_s2[1] <= $signed(u_s1[2]) * $signed(w_s1[0]);
			pb_s2[1] <= $signed(u_s1[0]) * $signed(w_s1[2]);
			pa_s2[2] <= $signed(u_s1[0]) * $signed(w_s1[1]);
			pb_s2[2] <= $signed(u_s1[1]) * $signed(w_s1[0]);
		end
	end

	// stage 3: cross product
	logic                 v_s3;
	logic signed [NB-1:0] n_s3 [0:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				n_s3[i] <= NB'(pa_s2[i]) - NB'(pb_s2[i]);
			end
		end
	end

	// stage 4: magnitudes and signs
	logic          v_s4;
	logic [NB-1:0] mag_s4 [0:2];
	logic [2:0]    neg_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				neg_s4[i] <= n_s3[i][NB-1];
				mag_s4[i] <= n_s3[i][NB-1] ? NB'(-n_s3[i]) : NB'(n_s3[i]);
			end
		end
	end

	// stage 5: shift count from the widest magnitude
	logic [NB-1:0]               all_mag;
	logic [tun_pkg::ShBits-1:0]  bl;
	logic [tun_pkg::ShBits-1:0]  sh;

	always_comb begin
		all_mag = mag_s4[0] | mag_s4[1] | mag_s4[2];
		bl = '0;
		for (int i = 0; i < NB; i++) begin
			if (all_mag[i]) bl = tun_pkg::ShBits'(i + 1);
		end
		sh = (bl > tun_pkg::ShBits'(RB)) ? bl - tun_pkg::ShBits'(RB) : '0;
	end

	logic                        v_s5;
	logic [NB-1:0]               mag_s5 [0:2];
	logic [2:0]                  neg_s5;
	logic                        dg_s5;
	logic [tun_pkg::ShBits-1:0]  sh_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s5 <= mag_s4;
			neg_s5 <= neg_s4;
			dg_s5  <= (all_mag == '0);
			sh_s5  <= sh;
		end
	end

	// stage 6: scale down to 31 bits
	logic             v_s6;
	tun_pkg::side_t   sd_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sd_s6.r[i] <= RB'(mag_s5[i] >> sh_s5);
			end
			sd_s6.neg   <= neg_s5;
			sd_s6.degen <= dg_s5;
		end
	end

	// stage 7: squares
	logic                           v_s7;
	logic [tun_pkg::SqBits-1:0]     sq_s7 [0:2];
	tun_pkg::side_t                 sd_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s7[i] <= sd_s6.r[i] * sd_s6.r[i];
			end
			sd_s7 <= sd_s6;
		end
	end

	// stage 8: sum of squares
	logic                         v_s8;
	logic [tun_pkg::SumBits-1:0]  sum_s8;
	tun_pkg::side_t               sd_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s8 <= tun_pkg::SumBits'(sq_s7[0]) + tun_pkg::SumBits'(sq_s7[1])
				+ tun_pkg::SumBits'(sq_s7[2]);
			sd_s8  <= sd_s7;
		end
	end

	logic                         sq_v;
	logic [tun_pkg::LenBits-1:0]  sq_len;
	tun_pkg::side_t               sq_sd;

	tun_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s8),
		.x        (sum_s8),
		.side_in  (sd_s8),
		.out_valid(sq_v),
		.len      (sq_len),
		.side_out (sq_sd)
	);

	// stage 9: rounding numerators
	logic                                 v_s9;
	logic [2:0][tun_pkg::NumBits-1:0]     num_s9;
	logic [tun_pkg::LenBits-1:0]          len_s9;
	tun_pkg::div_side_t                   dsd_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s9 <= sq_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				num_s9[i] <= (tun_pkg::NumBits'(sq_sd.r[i]) << tun_pkg::FracBits)
					+ tun_pkg::NumBits'(sq_len >> 1);
			end
			len_s9       <= sq_len;
			dsd_s9.neg   <= sq_sd.neg;
			dsd_s9.degen <= sq_sd.degen;
		end
	end

	logic                               dv_v;
	logic [2:0][tun_pkg::QBits-1:0]     dv_q;
	tun_pkg::div_side_t                 dv_sd;

	tun_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s9),
		.num      (num_s9),
		.den      (len_s9),
		.side_in  (dsd_s9),
		.out_valid(dv_v),
		.quo      (dv_q),
		.side_out (dv_sd)
	);

	// output register: sign applied, degenerate forced to zero
	logic [2:0][tun_pkg::OutBits-1:0] out_q;
	logic                             dg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= dv_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				if (dv_sd.degen) begin
					out_q[i] <= '0;
				end else if (dv_sd.neg[i]) begin
					out_q[i] <= tun_pkg::OutBits'(-tun_pkg::OutBits'(dv_q[i]));
				end else begin
					out_q[i] <= tun_pkg::OutBits'(dv_q[i]);
				end
			end
			dg_q <= dv_sd.degen;
		end
	end

	assign m_tvalid   = out_v_q;
	assign m_tdata    = out_q;
	assign m_tuser[0] = dg_q;

`ifndef NO_ASSERTIONS
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow output stall");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
		else $error("degenerate result with non-zero normal");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[15:0]) <= 16384 && $signed(m_tdata[15:0]) >= -16384))
		else $error("normal x out of range");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !en) |=> v_s1)
		else $error("pipeline stage lost a transaction during stall");
`endif

endmodule
